// ----- hw/rtl/rip_pkg.sv -----
// ----------------------------------------------------------------------------
// rip_pkg
// Shared types and constants of the radix integer parser: the classified
// character record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package rip_pkg;

   // Digit code of a byte that is no digit in any base up to 36
   localparam logic [5:0] NO_DIGIT = 6'd63;

   // Smallest and largest legal explicit radix
   localparam logic [5:0] RADIX_MIN = 6'd2;
   localparam logic [5:0] RADIX_MAX = 6'd36;

   // Default base and the two fixed bases of the prefix logic
   localparam logic [5:0] BASE_DEC = 6'd10;
   localparam logic [5:0] BASE_HEX = 6'd16;
   localparam logic [5:0] BASE_OCT = 6'd8;

   // Character codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LX    = 8'h78;

   // One classified character, as queued between front and back end
   typedef struct packed {
      logic [5:0] digit;      // digit value 0..35, NO_DIGIT otherwise
      logic       is_dec;     // '0'..'9'
      logic       is_space;   // space, LF, TAB, CR
      logic       is_minus;   // '-'
      logic       is_zero;    // '0'
      logic       is_x;       // 'x' or 'X'
      logic       first;
      logic       last;
      logic       has_radix;
      logic [5:0] radix;
   } rip_entry_type;

endpackage : rip_pkg

`default_nettype wire

// ----- hw/rtl/rip_front.sv -----
// ----------------------------------------------------------------------------
// rip_front
// Front end: decodes each incoming byte into a digit value and character
// class flags and hands the record to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rip_front
   import rip_pkg::*;
(
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [7:0]    req_ch,
   input  wire logic          req_first,
   input  wire logic          req_last,
   input  wire logic          req_has_radix,
   input  wire logic [5:0]    req_radix,
   output logic               push_valid,
   input  wire logic          push_ready,
   output rip_entry_type      push_entry
);

   logic       is_dec;
   logic       is_upper;
   logic       is_lower;
   logic [7:0] digit_wide;

   // Character classes
   assign is_dec   = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
   assign is_upper = (req_ch >= CH_UA) && (req_ch <= CH_UZ);
   assign is_lower = (req_ch >= CH_LA) && (req_ch <= CH_LZ);

   // Case-insensitive digit value
   always_comb begin
      if (is_dec) begin
         digit_wide = req_ch - CH_ZERO;
      end else if (is_upper) begin
         digit_wide = req_ch - CH_UA + 8'd10;
      end else if (is_lower) begin
         digit_wide = req_ch - CH_LA + 8'd10;
      end else begin
         digit_wide = {2'b00, NO_DIGIT};
      end
   end

   // Build the queued record
   always_comb begin
      push_entry.digit     = digit_wide[5:0];
      push_entry.is_dec    = is_dec;
      push_entry.is_space  = (req_ch == CH_SPACE) || (req_ch == CH_LF) ||
                             (req_ch == CH_TAB) || (req_ch == CH_CR);
      push_entry.is_minus  = (req_ch == CH_MINUS);
      push_entry.is_zero   = (req_ch == CH_ZERO);
      push_entry.is_x      = (req_ch == CH_UX) || (req_ch == CH_LX);
      push_entry.first     = req_first;
      push_entry.last      = req_last;
      push_entry.has_radix = req_has_radix;
      push_entry.radix     = req_radix;
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule : rip_front

`default_nettype wire

// ----- hw/rtl/rip_queue.sv -----
// ----------------------------------------------------------------------------
// rip_queue
// Two-entry queue of classified characters between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rip_queue
   import rip_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire rip_entry_type push_entry,
   output logic               pop_valid,
   input  wire logic          pop_ready,
   output rip_entry_type      pop_entry
);

   localparam int DEPTH = 2;

   rip_entry_type entry_ff [DEPTH];
   logic          wr_ptr_ff;
   logic          wr_ptr_in;
   logic          rd_ptr_ff;
   logic          rd_ptr_in;
   logic [1:0]    count_ff;
   logic [1:0]    count_in;
   logic          push;
   logic          pop;

   assign push_ready = (count_ff != 2'(DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = entry_ff[rd_ptr_ff];

   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule : rip_queue

`default_nettype wire

// ----- hw/rtl/rip_back.sv -----
// ----------------------------------------------------------------------------
// rip_back
// Back end: runs the parse state machine on one classified character per
// cycle unless a held result stalls it, keeps the current-base and octal
// accumulators, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rip_back
   import rip_pkg::*;
#(
   parameter int RESULT_WIDTH = 32
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          pop_valid,
   output logic               pop_ready,
   input  wire rip_entry_type pop_entry,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic               rsp_not_a_number
);

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_LEAD,
      PH_ZERO,
      PH_HEXLEAD,
      PH_DIGITS,
      PH_DUAL,
      PH_STOPPED
   } phase_type;

   localparam int PROD_WIDTH = RESULT_WIDTH + 6;

   phase_type               phase_ff,   phase_in;
   logic                    neg_ff,     neg_in;
   logic                    space_ff,   space_in;
   logic [5:0]              base_ff,    base_in;
   logic                    given_ff,   given_in;
   logic                    octal_ff,   octal_in;
   logic                    dstop_ff,   dstop_in;
   logic [RESULT_WIDTH-1:0] main_ff,    main_in;
   logic [RESULT_WIDTH-1:0] oct_ff,     oct_in;
   logic                    fail_ff,    fail_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             value_ff,   value_in;
   logic                    nan_ff,     nan_in;

   logic                    pop;
   logic [PROD_WIDTH-1:0]   prod;
   logic [RESULT_WIDTH-1:0] main_mac;
   logic [RESULT_WIDTH-1:0] oct_mac;
   logic [RESULT_WIDTH-1:0] digit_ext;
   logic                    digit_ok;
   logic                    nan;
   logic [RESULT_WIDTH-1:0] mag;
   logic [63:0]             mag_wide;

   // Pop whenever the output register is free or being drained
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;

   // Multiply-add of both accumulators
   assign prod      = PROD_WIDTH'(main_ff) * PROD_WIDTH'(base_ff);
   assign digit_ext = RESULT_WIDTH'(pop_entry.digit);
   assign main_mac  = prod[RESULT_WIDTH-1:0] + digit_ext;
   assign oct_mac   = {oct_ff[RESULT_WIDTH-4:0], pop_entry.digit[2:0]};

   // Parse step
   always_comb begin
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      space_in     = space_ff;
      base_in      = base_ff;
      given_in     = given_ff;
      octal_in     = octal_ff;
      dstop_in     = dstop_ff;
      main_in      = main_ff;
      oct_in       = oct_ff;
      fail_in      = fail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      value_in     = value_ff;
      nan_in       = nan_ff;
      digit_ok     = 1'b0;
      nan          = 1'b0;
      mag          = '0;
      mag_wide     = '0;

      if (pop) begin
         // Start of a new string: restart and sample the radix
         if (pop_entry.first) begin
            phase_in = PH_SPACE;
            neg_in   = 1'b0;
            space_in = 1'b0;
            base_in  = BASE_DEC;
            given_in = 1'b0;
            octal_in = 1'b1;
            dstop_in = 1'b0;
            main_in  = '0;
            oct_in   = '0;
            fail_in  = 1'b0;
            if (pop_entry.has_radix) begin
               given_in = 1'b1;
               base_in  = pop_entry.radix;
               if ((pop_entry.radix < RADIX_MIN) || (pop_entry.radix > RADIX_MAX)) begin
                  fail_in = 1'b1;
               end
            end
         end

         digit_ok = (pop_entry.digit < base_in);

         if (!fail_in) begin
            case (phase_in)
               PH_SPACE, PH_LEAD, PH_HEXLEAD: begin
                  if ((phase_in == PH_SPACE) && pop_entry.is_space) begin
                     space_in = 1'b1;
                  end else if ((phase_in == PH_SPACE) && pop_entry.is_minus) begin
                     neg_in   = 1'b1;
                     phase_in = PH_LEAD;
                  end else if ((phase_in != PH_HEXLEAD) && !given_in &&
                               pop_entry.is_zero) begin
                     main_in  = '0;
                     phase_in = PH_ZERO;
                  end else if (digit_ok) begin
                     main_in  = digit_ext;
                     phase_in = PH_DIGITS;
                  end else begin
                     fail_in = 1'b1;
                  end
               end
               PH_ZERO: begin
                  if (pop_entry.is_x) begin
                     base_in  = BASE_HEX;
                     phase_in = PH_HEXLEAD;
                  end else if (pop_entry.is_dec && !space_in) begin
                     main_in  = digit_ext;
                     oct_in   = digit_ext;
                     octal_in = (pop_entry.digit < BASE_OCT);
                     dstop_in = 1'b0;
                     phase_in = PH_DUAL;
                  end else if (digit_ok) begin
                     main_in  = digit_ext;
                     phase_in = PH_DIGITS;
                  end else begin
                     main_in  = '0;
                     phase_in = PH_STOPPED;
                  end
               end
               PH_DIGITS: begin
                  if (digit_ok) begin
                     main_in = main_mac;
                  end else begin
                     phase_in = PH_STOPPED;
                  end
               end
               PH_DUAL: begin
                  // base is ten here: no explicit radix reaches this phase
                  if (!dstop_in) begin
                     if (pop_entry.is_dec) begin
                        main_in = main_mac;
                     end else begin
                        dstop_in = 1'b1;
                     end
                  end
                  if (!(pop_entry.is_dec && (pop_entry.digit < BASE_OCT))) begin
                     octal_in = 1'b0;
                  end
                  if (octal_in) begin
                     oct_in = oct_mac;
                  end
               end
               default: begin
               end
            endcase
         end

         // End of string: form the result and restart
         if (pop_entry.last) begin
            nan = fail_in || (phase_in == PH_SPACE) || (phase_in == PH_LEAD) ||
                  (phase_in == PH_HEXLEAD);
            if ((phase_in == PH_DUAL) && octal_in) begin
               mag = oct_in;
            end else if (phase_in == PH_ZERO) begin
               mag = '0;
            end else begin
               mag = main_in;
            end
            if (neg_in) begin
               mag = RESULT_WIDTH'(0) - mag;
            end
            mag_wide     = 64'(mag);
            value_in     = nan ? 32'd0 : mag_wide[31:0];
            nan_in       = nan;
            rsp_valid_in = 1'b1;

            phase_in = PH_SPACE;
            neg_in   = 1'b0;
            space_in = 1'b0;
            base_in  = BASE_DEC;
            given_in = 1'b0;
            octal_in = 1'b1;
            dstop_in = 1'b0;
            main_in  = '0;
            oct_in   = '0;
            fail_in  = 1'b0;
         end
      end
   end

   // Parse state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SPACE;
         neg_ff       <= 1'b0;
         space_ff     <= 1'b0;
         base_ff      <= BASE_DEC;
         given_ff     <= 1'b0;
         octal_ff     <= 1'b1;
         dstop_ff     <= 1'b0;
         main_ff      <= '0;
         oct_ff       <= '0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         space_ff     <= space_in;
         base_ff      <= base_in;
         given_ff     <= given_in;
         octal_ff     <= octal_in;
         dstop_ff     <= dstop_in;
         main_ff      <= main_in;
         oct_ff       <= oct_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff <= value_in;
      nan_ff   <= nan_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = value_ff;
   assign rsp_not_a_number = nan_ff;

endmodule : rip_back

`default_nettype wire

// ----- hw/rtl/radix_integer_parser.sv -----
// ----------------------------------------------------------------------------
// radix_integer_parser
// String-to-integer parser with optional radix, one character per
// transaction; gives one result on the last character of each string.
// ----------------------------------------------------------------------------
//  Channel | Ports                                          | Direction
//  --------+------------------------------------------------+----------
//  request | req_valid/ready, ch, first, last, has_radix,   | in
//          | radix                                          |
//  result  | rsp_valid/ready, value, not_a_number           | out
//
//  One character per cycle sustained while results drain; a string's last
//  character passes a queue entry, then its result the output register.
//  The rate is set by the back end's combinational multiply-add loop.
//  Synchronous active-high reset empties the queue and the output register.
//  A stalled result side fills the two-entry queue before request stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_integer_parser
   import rip_pkg::*;
#(
   parameter int RESULT_WIDTH = 32
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [7:0]    req_ch,
   input  wire logic          req_first,
   input  wire logic          req_last,
   input  wire logic          req_has_radix,
   input  wire logic [5:0]    req_radix,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic               rsp_not_a_number
);

   logic          push_valid;
   logic          push_ready;
   rip_entry_type push_entry;
   logic          pop_valid;
   logic          pop_ready;
   rip_entry_type pop_entry;

   // Character classification
   rip_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_first     (req_first),
      .req_last      (req_last),
      .req_has_radix (req_has_radix),
      .req_radix     (req_radix),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_entry    (push_entry)
   );

   // Decoupling queue
   rip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Parse engine and result register
   rip_back #(
      .RESULT_WIDTH (RESULT_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_entry        (pop_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_not_a_number (rsp_not_a_number)
   );

endmodule : radix_integer_parser

`default_nettype wire
